// File: hw/rtl/cemf_pkg.sv
// package for the compass edge max filter: widths, kernel and window types
// no dependencies; imported by the interfaces, the kernel unit and the top level
`default_nettype none

package cemf_pkg;

  localparam int MaxWidth = 1024;
  localparam int AddrW    = $clog2(MaxWidth);
  localparam int CountW   = $clog2(MaxWidth + 1);

  localparam int ChanW   = 8;
  localparam int NumChan = 3;
  localparam int PixW    = NumChan * ChanW;
  localparam int NumTap  = 9;
  localparam int NumKer  = 8;
  localparam int CoefW   = 7;
  localparam int KerW    = NumTap * CoefW;
  localparam int CfgIdxW = $clog2(NumKer);
  localparam int ProdW   = ChanW + 1 + CoefW;
  localparam int SumW    = ProdW + $clog2(NumTap);

  localparam logic signed [SumW-1:0] ChanMaxS = SumW'(255);

  typedef logic [ChanW-1:0] chan_t;
  typedef logic [PixW-1:0] pixel_t;
  typedef pixel_t [NumTap-1:0] window_t;
  typedef logic [KerW-1:0] kernel_t;
  typedef kernel_t [NumKer-1:0] kernels_t;
  typedef chan_t [NumChan-1:0] result_t;

endpackage

`default_nettype wire

// File: hw/rtl/cemf_if.sv
// valid/ready channel interfaces for pixels in and filter results out
// depends on cemf_pkg for the field widths
`default_nettype none

interface cemf_pix_if import cemf_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t red;
  chan_t green;
  chan_t blue;
  logic  row_end;
  logic  fill;

  modport source (output valid, red, green, blue, row_end, fill, input ready);
  modport sink (input valid, red, green, blue, row_end, fill, output ready);
endinterface

interface cemf_res_if import cemf_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t red_out;
  chan_t green_out;
  chan_t blue_out;
  logic  row_last;
  logic  frame_last;

  modport source (output valid, red_out, green_out, blue_out, row_last, frame_last,
                  input ready);
  modport sink (input valid, red_out, green_out, blue_out, row_last, frame_last,
                output ready);
endinterface

`default_nettype wire

// File: hw/rtl/compass_edge_max_filter.sv
// compass edge max filter: 3x3 window, eight kernels, per-channel max
// pipeline: stage 1, the stage 2 window snapshot, then the output register
// throughput: one pixel per cycle unless stalled; a row-end pixel after the first row
//   holds stage 1 as its two results share the window unit (last column, column left)
// reset: control and kernels clear at once; the row memory is not swept, a fill count
//   makes never-written columns read as zero, so pixels are taken right after reset
`default_nettype none

module compass_edge_max_filter import cemf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  kernel_t            cfg_data_i,
  cemf_pix_if.sink           pix_i,
  cemf_res_if.source         res_o
);

  // shift a new column (top, middle, bottom) into the right edge of the window
  function automatic window_t shift_win(window_t w, pixel_t col_top, pixel_t col_mid,
                                        pixel_t col_bot);
    window_t r;
    r = w;
    for (int row = 0; row < 3; row++) begin
      r[row*3+0] = w[row*3+1];
      r[row*3+1] = w[row*3+2];
    end
    r[2] = col_top;
    r[5] = col_mid;
    r[8] = col_bot;
    return r;
  endfunction

  // kernel registers
  kernels_t kern_q;

  // front: column counter and row phase of the incoming pixel
  logic [AddrW-1:0]  col_q;
  logic              phase_q;
  logic [CountW-1:0] hw_q, hw_d;   // columns below this were written since reset

  // stage 1: accepted pixel plus its row memory read
  logic             s1_valid_q;
  pixel_t           s1_px_q;
  logic             s1_last_q;
  logic             s1_fill_q;
  logic             s1_phase_q;
  logic             s1_emit_q;
  logic [AddrW-1:0] s1_addr_q;
  logic             tail_q;        // row-end item waiting for its second result

  // row memory: older row in the upper half, newer row in the lower half
  logic [2*PixW-1:0] row_mem_q [MaxWidth];
  logic [2*PixW-1:0] rd_q;
  logic              rdv_q;
  logic              byp_q;
  logic [2*PixW-1:0] byp_data_q;

  window_t win_q;

  // stage 2: window snapshot for the kernel unit
  logic    e_valid_q;
  window_t e_win_q;
  logic    e_rl_q;
  logic    e_fl_q;

  // output register
  logic    out_valid_q;
  result_t out_res_q;
  logic    out_rl_q;
  logic    out_fl_q;
  result_t res_comb;

  logic              acc;
  pixel_t            px_in;
  logic [2*PixW-1:0] eff;
  pixel_t            top, mid;
  window_t           win_shift;
  logic              needs_tail;
  logic              main_go, tail_go, s1_free;
  logic              out_free, e_free, out_load, e_load;
  logic              wr_en;
  logic [AddrW-1:0]  wr_addr;
  logic [2*PixW-1:0] wr_data;

  // handshake chain, back to front
  assign out_free = !out_valid_q || res_o.ready;
  assign out_load = e_valid_q && out_free;
  assign e_free   = !e_valid_q || out_free;

  assign needs_tail = s1_phase_q && s1_last_q;
  assign main_go    = s1_valid_q && !tail_q && (!s1_emit_q || e_free);
  assign tail_go    = s1_valid_q && tail_q && e_free;
  assign s1_free    = (main_go && !needs_tail) || tail_go;
  assign e_load     = (main_go && s1_emit_q) || tail_go;

  assign pix_i.ready = !s1_valid_q || s1_free;
  assign acc         = pix_i.valid && pix_i.ready;
  assign px_in       = pix_i.fill ? '0 : {pix_i.red, pix_i.green, pix_i.blue};

  // row memory data: forwarded write, written entry, or zero for a fresh column
  assign eff = byp_q ? byp_data_q : (rdv_q ? rd_q : '0);
  assign top = eff[2*PixW-1:PixW];
  assign mid = eff[PixW-1:0];

  assign win_shift = shift_win(win_q, top, mid, s1_px_q);

  // first row of a frame pushes zeros into the older row
  assign wr_en   = main_go;
  assign wr_addr = s1_addr_q;
  assign wr_data = {(s1_phase_q ? mid : pixel_t'('0)), s1_px_q};

  assign hw_d = (wr_en && ({1'b0, wr_addr} >= hw_q)) ? CountW'({1'b0, wr_addr} + 1'b1) : hw_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      row_mem_q[wr_addr] <= wr_data;
    end
    if (acc) begin
      rd_q <= row_mem_q[col_q];
    end
  end

  cemf_kernel_max u_kernel_max (
    .win_i  (e_win_q),
    .kern_i (kern_q),
    .max_o  (res_comb)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kern_q      <= '0;
      col_q       <= '0;
      phase_q     <= 1'b0;
      hw_q        <= '0;
      s1_valid_q  <= 1'b0;
      tail_q      <= 1'b0;
      byp_q       <= 1'b0;
      rdv_q       <= 1'b0;
      win_q       <= '0;
      e_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        kern_q[cfg_idx_i] <= cfg_data_i;
      end
      hw_q <= hw_d;

      // front counters move on every transfer
      if (acc) begin
        if (pix_i.row_end) begin
          col_q   <= '0;
          phase_q <= !pix_i.fill;
        end else if (col_q != AddrW'(MaxWidth - 1)) begin
          col_q <= col_q + 1'b1;
        end
        rdv_q      <= ({1'b0, col_q} < hw_d);
        byp_q      <= wr_en && (wr_addr == col_q);
        byp_data_q <= wr_data;
        s1_px_q    <= px_in;
        s1_last_q  <= pix_i.row_end;
        s1_fill_q  <= pix_i.fill;
        s1_phase_q <= phase_q;
        s1_emit_q  <= phase_q && (col_q != '0);
        s1_addr_q  <= col_q;
      end

      if (acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_free) begin
        s1_valid_q <= 1'b0;
      end

      // window update
      if (main_go) begin
        if (s1_last_q && !s1_phase_q) begin
          win_q <= '0;
        end else begin
          win_q <= win_shift;
        end
        tail_q <= needs_tail;
      end else if (tail_go) begin
        win_q  <= '0;
        tail_q <= 1'b0;
      end

      // snapshot for the kernel unit
      if (e_load) begin
        e_valid_q <= 1'b1;
        e_win_q   <= main_go ? win_shift : shift_win(win_q, '0, '0, '0);
        e_rl_q    <= tail_go;
        e_fl_q    <= tail_go && s1_fill_q;
      end else if (out_load) begin
        e_valid_q <= 1'b0;
      end

      // result register
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_res_q   <= res_comb;
        out_rl_q    <= e_rl_q;
        out_fl_q    <= e_fl_q;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.red_out    = out_res_q[0];
  assign res_o.green_out  = out_res_q[1];
  assign res_o.blue_out   = out_res_q[2];
  assign res_o.row_last   = out_rl_q;
  assign res_o.frame_last = out_fl_q;

  // a pending second result always belongs to a held item
  assert property (@(posedge clk_i) disable iff (!rst_ni) tail_q |-> s1_valid_q)
    else $error("tail pending without an item in stage 1");

  // input stalls only while stage 1 is occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni) !pix_i.ready |-> s1_valid_q)
    else $error("input stalled with empty stage 1");

  // the window is cleared once a row's last result has been issued
  assert property (@(posedge clk_i) disable iff (!rst_ni) tail_go |=> (win_q == '0))
    else $error("window not cleared after row end");

  // a stalled snapshot must not change under the kernel unit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (e_valid_q && !out_free) |=> $stable(e_win_q))
    else $error("window snapshot changed while stalled");

  // the fill count never passes the row length
  assert property (@(posedge clk_i) disable iff (!rst_ni) hw_q <= CountW'(MaxWidth))
    else $error("fill count out of range");

endmodule

`default_nettype wire

// File: hw/rtl/cemf_kernel_max.sv
// eight 3x3 kernels per color channel, clamp to 0..255, keep the maximum
// combinational; depends on cemf_pkg
`default_nettype none

module cemf_kernel_max import cemf_pkg::*; (
  input  window_t  win_i,
  input  kernels_t kern_i,
  output result_t  max_o
);

  always_comb begin
    logic signed [SumW-1:0]  sum;
    logic signed [ProdW-1:0] prod;
    logic signed [ChanW:0]   pix_s;
    logic signed [CoefW-1:0] coef;
    chan_t                   clamp_v;
    chan_t                   best;
    for (int ch = 0; ch < NumChan; ch++) begin
      best = '0;
      for (int k = 0; k < NumKer; k++) begin
        sum = '0;
        for (int i = 0; i < NumTap; i++) begin
          pix_s = $signed({1'b0, win_i[i][(NumChan-1-ch)*ChanW +: ChanW]});
          coef  = $signed(kern_i[k][i*CoefW +: CoefW]);
          prod  = pix_s * coef;
          sum   = sum + SumW'(prod);
        end
        // clamp to the 8-bit range
        if (sum > ChanMaxS) begin
          clamp_v = '1;
        end else if (sum < 0) begin
          clamp_v = '0;
        end else begin
          clamp_v = sum[ChanW-1:0];
        end
        if (clamp_v > best) begin
          best = clamp_v;
        end
      end
      max_o[ch] = best;
    end
  end

endmodule

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// self-checking bench for compass_edge_max_filter: directed table, then random frames
// depends on cemf_pkg and the cemf_pix_if / cemf_res_if channel interfaces

module tb_top;
  import cemf_pkg::*;

  localparam int ClkHalfNs    = 5;
  localparam int RandomItems  = 1230;
  localparam int CalmItems    = 100;   // tail of the run with no idling on either side
  localparam int LongRowAt    = 0;     // random item count at which the overlong row goes out
  localparam int SettleCycles = 4;     // result register sits behind stage 1 and stage 2
  localparam int DrainLimit   = 5000;
  localparam int TimeoutNs    = 5_000_000;
  localparam int ChanCeil     = (1 << ChanW) - 1;
  localparam int CoefMax      = (1 << (CoefW - 1)) - 1;
  localparam int CoefMin      = -(1 << (CoefW - 1));
  localparam int MaxReports   = 10;

  // outer taps of a 3x3 kernel in clockwise order, starting top left
  localparam int Ring [8] = '{0, 1, 2, 5, 8, 7, 6, 3};

  typedef enum logic [2:0] {
    KSET_ZERO,
    KSET_ALL_POS,
    KSET_ALL_NEG,
    KSET_COMPASS,
    KSET_SMALL,
    KSET_WIDE
  } kernel_set_e;

  typedef enum logic {
    ROW_KERNELS,
    ROW_PIXEL
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    kernel_set_e kset;
    chan_t       red;
    chan_t       green;
    chan_t       blue;
    logic        row_end;
    logic        fill;
    logic        typed;      // expected channels given below instead of computed
    chan_t       typed_val;
  } stim_row_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  row_last;
    logic  frame_last;
  } filter_res_t;

  // directed stimulus; typed values only where the answer is obvious
  stim_row_t directed_rows [26] = '{
    // reset kernels are all zero, so every response is zero
    '{ROW_PIXEL,   KSET_ZERO,    8'd255, 8'd255, 8'd255, 1'b1, 1'b0, 1'b1, 8'd0},
    '{ROW_PIXEL,   KSET_ZERO,    8'd200, 8'd100, 8'd50,  1'b1, 1'b1, 1'b1, 8'd0},
    // every coefficient at its top value saturates any window whose taps sum to 5 or more
    '{ROW_KERNELS, KSET_ALL_POS, 8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 1'b0, 8'd0},
    '{ROW_PIXEL,   KSET_ZERO,    8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 1'b1, 8'd255},
    '{ROW_PIXEL,   KSET_ZERO,    8'd5,   8'd200, 8'd17,  1'b1, 1'b0, 1'b1, 8'd255},
    '{ROW_PIXEL,   KSET_ZERO,    8'd90,  8'd6,   8'd255, 1'b0, 1'b0, 1'b1, 8'd255},
    '{ROW_PIXEL,   KSET_ZERO,    8'd255, 8'd255, 8'd255, 1'b1, 1'b0, 1'b1, 8'd255},
    '{ROW_PIXEL,   KSET_ZERO,    8'd0,   8'd0,   8'd0,   1'b0, 1'b1, 1'b1, 8'd255},
    '{ROW_PIXEL,   KSET_ZERO,    8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 1'b1, 8'd255},
    // every coefficient at its bottom value: all sums clamp to zero
    '{ROW_KERNELS, KSET_ALL_NEG, 8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 1'b0, 8'd0},
    '{ROW_PIXEL,   KSET_ZERO,    8'd255, 8'd255, 8'd255, 1'b1, 1'b0, 1'b1, 8'd0},
    '{ROW_PIXEL,   KSET_ZERO,    8'd0,   8'd0,   8'd0,   1'b1, 1'b0, 1'b1, 8'd0},
    '{ROW_PIXEL,   KSET_ZERO,    8'd255, 8'd0,   8'd255, 1'b1, 1'b1, 1'b1, 8'd0},
    // compass kernels: lone fill row, mid-row fill, rows of unequal length
    '{ROW_KERNELS, KSET_COMPASS, 8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 1'b0, 8'd0},
    '{ROW_PIXEL,   KSET_ZERO,    8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 1'b0, 8'd0},
    '{ROW_PIXEL,   KSET_ZERO,    8'd12,  8'd34,  8'd56,  1'b0, 1'b0, 1'b0, 8'd0},
    '{ROW_PIXEL,   KSET_ZERO,    8'd200, 8'd0,   8'd77,  1'b0, 1'b0, 1'b0, 8'd0},
    '{ROW_PIXEL,   KSET_ZERO,    8'd255, 8'd128, 8'd1,   1'b1, 1'b0, 1'b0, 8'd0},
    '{ROW_PIXEL,   KSET_ZERO,    8'd0,   8'd255, 8'd9,   1'b0, 1'b0, 1'b0, 8'd0},
    '{ROW_PIXEL,   KSET_ZERO,    8'd77,  8'd88,  8'd99,  1'b0, 1'b1, 1'b0, 8'd0},
    '{ROW_PIXEL,   KSET_ZERO,    8'd140, 8'd70,  8'd35,  1'b1, 1'b0, 1'b0, 8'd0},
    '{ROW_PIXEL,   KSET_ZERO,    8'd1,   8'd2,   8'd3,   1'b0, 1'b0, 1'b0, 8'd0},
    '{ROW_PIXEL,   KSET_ZERO,    8'd250, 8'd251, 8'd252, 1'b1, 1'b0, 1'b0, 8'd0},
    '{ROW_PIXEL,   KSET_ZERO,    8'd9,   8'd9,   8'd9,   1'b0, 1'b1, 1'b0, 8'd0},
    '{ROW_PIXEL,   KSET_ZERO,    8'd9,   8'd9,   8'd9,   1'b0, 1'b1, 1'b0, 8'd0},
    '{ROW_PIXEL,   KSET_ZERO,    8'd9,   8'd9,   8'd9,   1'b1, 1'b1, 1'b0, 8'd0}
  };

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  kernel_t            cfg_data;

  cemf_pix_if pix_if ();
  cemf_res_if res_if ();

  compass_edge_max_filter dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_i      (pix_if),
    .res_o      (res_if)
  );

  // shadow of the filter: kernels, both row stores, the 3x3 window, column and phase
  kernel_t     kernel_bank [NumKer] = '{default: '0};
  pixel_t      older_row [MaxWidth] = '{default: '0};
  pixel_t      newer_row [MaxWidth] = '{default: '0};
  pixel_t      window [NumTap]      = '{default: '0};
  int unsigned col_count = 0;
  logic        first_row = 1'b1;

  filter_res_t expected_results [$];

  // typed-in expectation that travels with the pixel on the bus
  logic  pix_typed;
  chan_t pix_typed_val;

  int src_gap_pct    = 0;
  int sink_stall_pct = 0;
  int stall_left     = 0;

  int pix_sent      = 0;
  int res_checked   = 0;
  int frames_done   = 0;
  int kernel_writes = 0;
  int mismatches    = 0;

  always begin
    clk = 1'b0;
    #(ClkHalfNs);
    clk = 1'b1;
    #(ClkHalfNs);
  end

  // result side back-pressure: ready dropped in random bursts of stalled cycles
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      res_if.ready <= 1'b0;
    end else if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
      stall_left   <= $urandom_range(0, 11);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  function automatic kernel_t kernel_for(kernel_set_e kset, int rot);
    int      coefs [NumTap];
    kernel_t k;
    k = '0;
    for (int i = 0; i < NumTap; i++) begin
      case (kset)
        KSET_ALL_POS: coefs[i] = CoefMax;
        KSET_ALL_NEG: coefs[i] = CoefMin;
        KSET_SMALL:   coefs[i] = $urandom_range(0, 4) - 2;
        default:      coefs[i] = 0;
      endcase
    end
    // compass: three taps of +5 rotating around the ring, -3 elsewhere, zero center
    if (kset == KSET_COMPASS) begin
      for (int j = 0; j < 8; j++) begin
        coefs[Ring[j]] = (((j - rot + 8) % 8) < 3) ? 5 : -3;
      end
    end
    for (int i = 0; i < NumTap; i++) begin
      k[CoefW*i +: CoefW] = coefs[i][CoefW-1:0];
    end
    if (kset == KSET_WIDE) begin
      k = kernel_t'({$urandom, $urandom});
    end
    return k;
  endfunction

  function automatic void shift_column(pixel_t top, pixel_t mid, pixel_t bot);
    pixel_t incoming [3];
    incoming = '{top, mid, bot};
    for (int r = 0; r < 3; r++) begin
      window[r*3]     = window[r*3 + 1];
      window[r*3 + 1] = window[r*3 + 2];
      window[r*3 + 2] = incoming[r];
    end
  endfunction

  // per channel: eight kernel sums, each clamped to the channel range, largest wins
  function automatic filter_res_t filter_window(logic row_last, logic frame_last);
    filter_res_t res;
    chan_t       best [NumChan];
    int          sum;
    int          peak;
    for (int ch = 0; ch < NumChan; ch++) begin
      peak = 0;
      for (int k = 0; k < NumKer; k++) begin
        sum = 0;
        for (int i = 0; i < NumTap; i++) begin
          sum += int'(window[i][PixW - ChanW*(ch + 1) +: ChanW]) *
                 int'($signed(kernel_bank[k][CoefW*i +: CoefW]));
        end
        if (sum > ChanCeil) sum = ChanCeil;
        if (sum < 0) sum = 0;
        if (sum > peak) peak = sum;
      end
      best[ch] = chan_t'(peak);
    end
    res.red        = best[0];
    res.green      = best[1];
    res.blue       = best[2];
    res.row_last   = row_last;
    res.frame_last = frame_last;
    return res;
  endfunction

  // one accepted pixel: update the stores and window, queue the results it causes
  function automatic void advance_window(chan_t r, chan_t g, chan_t b, logic re, logic fl,
                                         logic typed, chan_t typed_val);
    pixel_t      px;
    pixel_t      top;
    pixel_t      mid;
    int unsigned a;
    int          first_new;
    first_new = expected_results.size();
    px  = fl ? '0 : {r, g, b};
    a   = (col_count > MaxWidth - 1) ? MaxWidth - 1 : col_count;
    top = older_row[a];
    mid = newer_row[a];
    // first row of a frame leaves zeros behind as the row above it
    older_row[a] = first_row ? '0 : mid;
    newer_row[a] = px;
    shift_column(top, mid, px);
    if (!first_row && col_count >= 1) begin
      expected_results.push_back(filter_window(1'b0, 1'b0));
    end
    // row end flushes the last column against zero padding on the right
    if (!first_row && re) begin
      shift_column('0, '0, '0);
      expected_results.push_back(filter_window(1'b1, fl));
    end
    if (typed) begin
      for (int i = first_new; i < expected_results.size(); i++) begin
        expected_results[i].red   = typed_val;
        expected_results[i].green = typed_val;
        expected_results[i].blue  = typed_val;
      end
    end
    if (re) begin
      window    = '{default: '0};
      col_count = 0;
      first_row = fl;
    end else if (col_count < MaxWidth - 1) begin
      col_count++;
    end
  endfunction

  function automatic void check_result(filter_res_t got);
    filter_res_t want;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= MaxReports) begin
        $display("unexpected result: r=%0d g=%0d b=%0d row_last=%0b frame_last=%0b",
                 got.red, got.green, got.blue, got.row_last, got.frame_last);
      end
      return;
    end
    want = expected_results.pop_front();
    res_checked++;
    if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
        got.row_last !== want.row_last || got.frame_last !== want.frame_last) begin
      mismatches++;
      if (mismatches <= MaxReports) begin
        $display("result %0d mismatch: expected r=%0d g=%0d b=%0d rl=%0b fl=%0b", res_checked,
                 want.red, want.green, want.blue, want.row_last, want.frame_last);
        $display("                      actual r=%0d g=%0d b=%0d rl=%0b fl=%0b",
                 got.red, got.green, got.blue, got.row_last, got.frame_last);
      end
    end
  endfunction

  // everything is sampled on the rising edge; results trail their pixels through the filter's registers
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        kernel_bank[cfg_idx] = cfg_data;
        kernel_writes++;
      end
      if (pix_if.valid && pix_if.ready) begin
        advance_window(pix_if.red, pix_if.green, pix_if.blue, pix_if.row_end, pix_if.fill,
                       pix_typed, pix_typed_val);
        pix_sent++;
        if (pix_if.row_end && pix_if.fill) frames_done++;
      end
      if (res_if.valid && res_if.ready) begin
        check_result('{res_if.red_out, res_if.green_out, res_if.blue_out,
                       res_if.row_last, res_if.frame_last});
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_pixel(chan_t r, chan_t g, chan_t b, logic re, logic fl,
                            logic typed, chan_t typed_val);
    if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
      pix_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    pix_if.valid   <= 1'b1;
    pix_if.red     <= r;
    pix_if.green   <= g;
    pix_if.blue    <= b;
    pix_if.row_end <= re;
    pix_if.fill    <= fl;
    pix_typed      <= typed;
    pix_typed_val  <= typed_val;
    do @(posedge clk); while (!pix_if.ready);
    @(negedge clk);
  endtask

  function automatic chan_t rand_chan(bit smooth, int base);
    if (smooth) return chan_t'(base + $urandom_range(0, 20));
    return chan_t'($urandom_range(0, ChanCeil));
  endfunction

  // one row of len pixels; a fill row carries random values that must be ignored
  task automatic send_row(int len, bit fill_row, bit smooth, int base);
    logic re;
    logic fl;
    for (int c = 0; c < len; c++) begin
      re = (c == len - 1);
      fl = fill_row || (!re && $urandom_range(0, 99) < 4);
      send_pixel(rand_chan(smooth, base), rand_chan(smooth, base), rand_chan(smooth, base),
                 re, fl, 1'b0, '0);
    end
  endtask

  // kernels only change with no pixel in flight and no result outstanding
  task automatic settle_block();
    pix_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic load_kernels(kernel_set_e kset);
    for (int k = 0; k < NumKer; k++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= k[CfgIdxW-1:0];
      cfg_data <= kernel_for(kset, k);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    int random_start;
    int width;
    int len;
    int base;
    bit smooth;
    bit long_done;
    int frame_idx;

    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_data       = '0;
    pix_if.valid   = 1'b0;
    pix_if.red     = '0;
    pix_if.green   = '0;
    pix_if.blue    = '0;
    pix_if.row_end = 1'b0;
    pix_if.fill    = 1'b0;
    res_if.ready   = 1'b0;
    pix_typed      = 1'b0;
    pix_typed_val  = '0;
    long_done      = 1'b0;
    frame_idx      = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part with moderate idling on both sides
    src_gap_pct    = 20;
    sink_stall_pct = 20;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_KERNELS) begin
        settle_block();
        load_kernels(directed_rows[i].kset);
      end else begin
        send_pixel(directed_rows[i].red, directed_rows[i].green, directed_rows[i].blue,
                   directed_rows[i].row_end, directed_rows[i].fill,
                   directed_rows[i].typed, directed_rows[i].typed_val);
      end
    end

    // random frames: mostly well formed, some lone fill rows and frames left open
    random_start = pix_sent;
    while (pix_sent - random_start < RandomItems) begin
      if (pix_sent - random_start >= RandomItems - CalmItems) begin
        src_gap_pct    = 0;
        sink_stall_pct = 0;
      end else begin
        src_gap_pct    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
        sink_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
      end
      if (frame_idx % 4 == 0) begin
        settle_block();
        load_kernels(kernel_set_e'($urandom_range(0, int'(KSET_WIDE))));
      end
      frame_idx++;
      smooth = $urandom_range(0, 1);
      base   = $urandom_range(0, ChanCeil - 20);
      width  = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 10) : $urandom_range(11, 48);

      if (!long_done && pix_sent - random_start >= LongRowAt) begin
        // row longer than the stores: column saturates on the last entry
        send_row(5, 1'b0, smooth, base);
        send_row(MaxWidth + 6, 1'b0, smooth, base);
        send_row(3, 1'b1, smooth, base);
        long_done = 1'b1;
      end else if ($urandom_range(0, 99) < 8) begin
        // fill row, in the first-row phase unless the last frame was left open
        send_row(width, 1'b1, smooth, base);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          len = width;
          if ($urandom_range(0, 9) == 0) len = $urandom_range(1, width + 3);
          send_row(len, 1'b0, smooth, base);
        end
        if ($urandom_range(0, 99) >= 5) begin
          len = width;
          if ($urandom_range(0, 9) == 0) len = $urandom_range(1, width + 3);
          send_row(len, 1'b1, smooth, base);
        end
      end
    end

    // drain: wait for the outstanding results, then a few more cycles for strays
    pix_if.valid <= 1'b0;
    for (int n = 0; n < DrainLimit && expected_results.size() != 0; n++) @(negedge clk);
    repeat (SettleCycles * 4) @(negedge clk);

    $display("covered %0d pixel transfers over %0d closed frames, %0d results checked",
             pix_sent, frames_done, res_checked);
    $display("kernel register writes %0d, mismatches %0d, still outstanding %0d",
             kernel_writes, mismatches, expected_results.size());
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #(TimeoutNs);
    $display("FAIL");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/cemf_pkg.sv
hw/rtl/cemf_if.sv
hw/rtl/cemf_kernel_max.sv
hw/rtl/compass_edge_max_filter.sv
dv/tb_top.sv
